// ----- rtl/cbcp_pkg.sv -----
package cbcp_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 8;
  localparam int SIZE_BITS  = 15;
  localparam int GAP_BITS   = COORD_BITS + 1;
  localparam int DIFF_BITS  = COORD_BITS;
  localparam int SQ_BITS    = 2 * DIFF_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;
  localparam int RAD_BITS   = 2 * GAP_BITS;
  localparam int REM_BITS   = GAP_BITS + 1;
  localparam int WREM_BITS  = GAP_BITS + 3;
  localparam int EXT_BITS   =
    ((COORD_BITS > SIZE_BITS + FRAC_BITS) ? COORD_BITS : SIZE_BITS + FRAC_BITS) + 2;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] centre_x;
    logic signed [COORD_BITS-1:0] centre_y;
    logic signed [COORD_BITS-1:0] box_left;
    logic signed [COORD_BITS-1:0] box_top;
    logic        [SIZE_BITS-1:0]  box_width;
    logic        [SIZE_BITS-1:0]  box_height;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic        [GAP_BITS-1:0]   gap;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic        [DIFF_BITS-1:0]  dx;
    logic        [DIFF_BITS-1:0]  dy;
  } clamp_item_t;

endpackage

// ----- rtl/cbcp_front.sv -----
module cbcp_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  cbcp_pkg::in_item_t     in_data,
  output logic                   push_valid,
  input  logic                   push_full,
  output cbcp_pkg::clamp_item_t  push_data
);
  import cbcp_pkg::*;

  logic                       front_v_r;
  logic                       front_v_nxt;
  clamp_item_t                item_r;
  clamp_item_t                item_nxt;
  logic                       in_take;
  logic                       push_take;
  logic signed [EXT_BITS-1:0] cx_e, cy_e, left_e, top_e, w_e, h_e;
  logic signed [EXT_BITS-1:0] right_e, bottom_e, mx, my, nx, ny, ddx, ddy;

  assign in_stall   = front_v_r && push_full;
  assign in_take    = in_valid && !in_stall;
  assign push_valid = front_v_r;
  assign push_take  = front_v_r && !push_full;
  assign push_data  = item_r;

  always_comb begin
    cx_e     = {{(EXT_BITS-COORD_BITS){in_data.centre_x[COORD_BITS-1]}}, in_data.centre_x};
    cy_e     = {{(EXT_BITS-COORD_BITS){in_data.centre_y[COORD_BITS-1]}}, in_data.centre_y};
    left_e   = {{(EXT_BITS-COORD_BITS){in_data.box_left[COORD_BITS-1]}}, in_data.box_left};
    top_e    = {{(EXT_BITS-COORD_BITS){in_data.box_top[COORD_BITS-1]}}, in_data.box_top};
    w_e      = EXT_BITS'({in_data.box_width, {FRAC_BITS{1'b0}}});
    h_e      = EXT_BITS'({in_data.box_height, {FRAC_BITS{1'b0}}});
    right_e  = left_e + w_e;
    bottom_e = top_e + h_e;
    mx       = (cx_e < right_e) ? cx_e : right_e;
    my       = (cy_e < bottom_e) ? cy_e : bottom_e;
    nx       = (mx > left_e) ? mx : left_e;
    ny       = (my > top_e) ? my : top_e;
    ddx      = (cx_e >= nx) ? (cx_e - nx) : (nx - cx_e);
    ddy      = (cy_e >= ny) ? (cy_e - ny) : (ny - cy_e);
    item_nxt.near_x = nx[COORD_BITS-1:0];
    item_nxt.near_y = ny[COORD_BITS-1:0];
    item_nxt.dx     = ddx[DIFF_BITS-1:0];
    item_nxt.dy     = ddy[DIFF_BITS-1:0];
  end

  always_comb begin
    front_v_nxt = front_v_r;
    if (in_take) begin
      front_v_nxt = 1'b1;
    end else if (push_take) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- rtl/cbcp_queue.sv -----
module cbcp_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_full,
  input  cbcp_pkg::clamp_item_t  push_data,
  input  logic                   pop_ready,
  output logic                   pop_valid,
  output cbcp_pkg::clamp_item_t  pop_data
);
  import cbcp_pkg::*;

  clamp_item_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_BITS-1:0] count_r, count_nxt;
  logic                      do_push;
  logic                      do_pop;

  assign push_full = (count_r == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/cbcp_back.sv -----
module cbcp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  cbcp_pkg::clamp_item_t  pop_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output cbcp_pkg::out_item_t    out_data
);
  import cbcp_pkg::*;

  logic                         adv;
  logic                         mul_v_r;
  logic [SQ_BITS-1:0]           sq_x_r, sq_y_r;
  logic signed [COORD_BITS-1:0] mul_nx_r, mul_ny_r;
  logic [SUM_BITS-1:0]          sum;

  logic                         v_r    [GAP_BITS+1];
  logic [RAD_BITS-1:0]          rad_r  [GAP_BITS+1];
  logic [REM_BITS-1:0]          rem_r  [GAP_BITS+1];
  logic [GAP_BITS-1:0]          root_r [GAP_BITS+1];
  logic signed [COORD_BITS-1:0] nx_r   [GAP_BITS+1];
  logic signed [COORD_BITS-1:0] ny_r   [GAP_BITS+1];

  assign adv       = !(v_r[GAP_BITS] && out_stall);
  assign pop_ready = adv;
  assign sum       = SUM_BITS'(sq_x_r) + SUM_BITS'(sq_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      v_r[0]  <= 1'b0;
    end else if (adv) begin
      mul_v_r <= pop_valid;
      v_r[0]  <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x_r    <= SQ_BITS'({{DIFF_BITS{1'b0}}, pop_data.dx} * {{DIFF_BITS{1'b0}}, pop_data.dx});
      sq_y_r    <= SQ_BITS'({{DIFF_BITS{1'b0}}, pop_data.dy} * {{DIFF_BITS{1'b0}}, pop_data.dy});
      mul_nx_r  <= pop_data.near_x;
      mul_ny_r  <= pop_data.near_y;
      rad_r[0]  <= RAD_BITS'(sum);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      nx_r[0]   <= mul_nx_r;
      ny_r[0]   <= mul_ny_r;
    end
  end

  for (genvar k = 0; k < GAP_BITS; k++) begin : g_root
    logic [WREM_BITS-1:0] wrem;
    logic [WREM_BITS-1:0] trial;
    logic                 fits;

    always_comb begin
      wrem  = {rem_r[k], rad_r[k][RAD_BITS-1 -: 2]};
      trial = WREM_BITS'({root_r[k], 2'b01});
      fits  = (wrem >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k+1]  <= rad_r[k] << 2;
        rem_r[k+1]  <= fits ? REM_BITS'(wrem - trial) : REM_BITS'(wrem);
        root_r[k+1] <= {root_r[k][GAP_BITS-2:0], fits};
        nx_r[k+1]   <= nx_r[k];
        ny_r[k+1]   <= ny_r[k];
      end
    end
  end

  assign out_valid       = v_r[GAP_BITS];
  assign out_data.near_x = nx_r[GAP_BITS];
  assign out_data.near_y = ny_r[GAP_BITS];
  assign out_data.gap    = root_r[GAP_BITS];

endmodule

// ----- rtl/circle_box_closest_point_unit.sv -----
// Throughput: one item per cycle while out_stall is low, set by the clamp
// stage, the squaring stage, and a square root unrolled into one pipeline
// stage per result bit.
// A four-entry queue separates the clamp front end from the arithmetic back end.
// Reset clears only valid flags, queue pointers and count; data is not reset.
module circle_box_closest_point_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cbcp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cbcp_pkg::out_item_t  out_data
);
  import cbcp_pkg::*;

  logic        push_valid;
  logic        push_full;
  clamp_item_t push_data;
  logic        pop_valid;
  logic        pop_ready;
  clamp_item_t pop_data;

  cbcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data)
  );

  cbcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data),
    .pop_ready  (pop_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  cbcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import cbcp_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t expected_q[$];
  out_item_t exp_item;
  dir_row_t  directed_rows[$];
  int        errors_seen = 0;
  int        quiet_cycles = 0;
  int        burst_left = 0;
  int        stall_mode = 0;
  int        stall_phase = 0;

  circle_box_closest_point_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic out_item_t closest_point(in_item_t q);
    longint cx, cy, x_lo, y_lo, x_hi, y_hi, nx, ny, dx, dy;
    longint unsigned rem, root, probe;
    out_item_t r;
    cx = longint'(q.centre_x);
    cy = longint'(q.centre_y);
    x_lo = longint'(q.box_left);
    y_lo = longint'(q.box_top);
    x_hi = x_lo + (longint'(q.box_width) << FRAC_BITS);
    y_hi = y_lo + (longint'(q.box_height) << FRAC_BITS);
    nx = (cx < x_hi) ? cx : x_hi;
    if (nx < x_lo) nx = x_lo;
    ny = (cy < y_hi) ? cy : y_hi;
    if (ny < y_lo) ny = y_lo;
    dx = (cx >= nx) ? cx - nx : nx - cx;
    dy = (cy >= ny) ? cy - ny : ny - cy;
    rem = dx * dx + dy * dy;
    root = 0;
    probe = 64'h1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    r.near_x = nx[COORD_BITS-1:0];
    r.near_y = ny[COORD_BITS-1:0];
    r.gap = root[GAP_BITS-1:0];
    return r;
  endfunction

  function automatic dir_row_t mk_row(int cx, int cy, int lft, int tp, int w, int h,
                                      bit typed, int nx, int ny, int g);
    dir_row_t r;
    r.stim.centre_x = cx[COORD_BITS-1:0];
    r.stim.centre_y = cy[COORD_BITS-1:0];
    r.stim.box_left = lft[COORD_BITS-1:0];
    r.stim.box_top = tp[COORD_BITS-1:0];
    r.stim.box_width = w[SIZE_BITS-1:0];
    r.stim.box_height = h[SIZE_BITS-1:0];
    r.typed = typed;
    r.want.near_x = nx[COORD_BITS-1:0];
    r.want.near_y = ny[COORD_BITS-1:0];
    r.want.gap = g[GAP_BITS-1:0];
    return r;
  endfunction

  task automatic send_item(in_item_t item, bit typed, out_item_t want, bit allow_gaps);
    int gap_len;
    gap_len = 0;
    if (allow_gaps) begin
      if (burst_left == 0) begin
        gap_len = $urandom_range(1, 10);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    if (gap_len != 0) begin
      in_valid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(typed ? want : closest_point(item));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    in_item_t item;
    longint   x_lo, y_lo;
    int       span_x, span_y;
    int       kind;

    directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    directed_rows.push_back(mk_row(100, 200, -256, -256, 4, 4, 1, 100, 200, 0));
    directed_rows.push_back(mk_row(-768, 0, 0, 0, 1, 1, 1, 0, 0, 768));
    directed_rows.push_back(mk_row(-768, -1024, 0, 0, 2, 2, 1, 0, 0, 1280));
    directed_rows.push_back(mk_row(512, 100, 0, 0, 0, 5, 1, 0, 100, 512));
    directed_rows.push_back(mk_row(3328, 2304, 0, 0, 10, 5, 1, 2560, 1280, 1280));
    directed_rows.push_back(mk_row(8388607, 8388607, 8388607, 8388607, 32767, 32767,
                                   1, 8388607, 8388607, 0));
    directed_rows.push_back(mk_row(-8388608, -8388608, -8388608, -8388608, 32767, 32767,
                                   1, -8388608, -8388608, 0));
    directed_rows.push_back(mk_row(-8388608, -8388608, 8388607, 8388607, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(8388607, 8388607, -8388608, -8388608, 32767, 32767,
                                   0, 0, 0, 0));
    directed_rows.push_back(mk_row(8388607, -8388608, -8388608, 8388607, 0, 32767,
                                   0, 0, 0, 0));
    directed_rows.push_back(mk_row('hAAAAAA, 'h555555, 'h555555, 'hAAAAAA, 'h2AAA, 'h5555,
                                   0, 0, 0, 0));
    directed_rows.push_back(mk_row('h555555, 'hAAAAAA, 'hAAAAAA, 'h555555, 'h5555, 'h2AAA,
                                   0, 0, 0, 0));
    directed_rows.push_back(mk_row(-1, -1, -1, -1, 32767, 32767, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(1000, -50, -300, -200, 3, 1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(300, -5000, 0, 0, 2, 2, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(-3, 7, -2, 5, 0, 0, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want, 1'b1);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      kind = $urandom_range(0, 7);
      item.centre_x = COORD_BITS'($urandom);
      item.centre_y = COORD_BITS'($urandom);
      item.box_left = COORD_BITS'($urandom);
      item.box_top = COORD_BITS'($urandom);
      item.box_width = SIZE_BITS'($urandom);
      item.box_height = SIZE_BITS'($urandom);
      // Most transfers place the centre inside or close around a small box.
      if (kind >= 2) begin
        item.box_width = SIZE_BITS'($urandom_range(0, 48));
        item.box_height = SIZE_BITS'($urandom_range(0, 48));
        if (kind == 2) item.box_width = '0;
        x_lo = longint'(item.box_left);
        y_lo = longint'(item.box_top);
        span_x = int'(item.box_width) << FRAC_BITS;
        span_y = int'(item.box_height) << FRAC_BITS;
        if (kind == 3 || kind == 4) begin
          item.centre_x = COORD_BITS'(x_lo + longint'($urandom_range(span_x, 0)));
          item.centre_y = COORD_BITS'(y_lo + longint'($urandom_range(span_y, 0)));
        end else begin
          item.centre_x = COORD_BITS'(x_lo + longint'($urandom_range(span_x + 8192, 0)) - 4096);
          item.centre_y = COORD_BITS'(y_lo + longint'($urandom_range(span_y + 8192, 0)) - 4096);
        end
      end
      send_item(item, 1'b0, '0, !(n >= 100 && n < 180));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors_seen == 0) begin
      $display("circle_box_closest_point_unit verification clean");
    end else begin
      $display("circle_box_closest_point_unit verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_phase <= $urandom_range(20, 100);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no expectation pending: %h", out_data);
        errors_seen++;
      end else begin
        exp_item = expected_q.pop_front();
        if (out_data.near_x !== exp_item.near_x) begin
          $error("near_x: expected %0d, got %0d", exp_item.near_x, out_data.near_x);
          errors_seen++;
        end
        if (out_data.near_y !== exp_item.near_y) begin
          $error("near_y: expected %0d, got %0d", exp_item.near_y, out_data.near_y);
          errors_seen++;
        end
        if (out_data.gap !== exp_item.gap) begin
          $error("gap: expected %0d, got %0d", exp_item.gap, out_data.gap);
          errors_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("circle_box_closest_point_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
rtl/cbcp_pkg.sv
rtl/cbcp_front.sv
rtl/cbcp_queue.sv
rtl/cbcp_back.sv
rtl/circle_box_closest_point_unit.sv
test/tb_top.sv
